// ----- hdl/qei_pkg.sv -----
// ----------------------------------------------------------------------------
// qei_pkg
// Shared types and constants of the quadrature encoder interface.
// ----------------------------------------------------------------------------
package qei_pkg;

  localparam int FILTER_LEN_DEF  = 6;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_W      = 17;      // config data width
  localparam int ANGLE_W    = 15;
  localparam int ANGLE_TURN = 23040;   // 1/64 degree per turn
  localparam int COUNTS_RST = 4096;
  localparam int COUNTS_MIN = 4;
  localparam int BAD_LIMIT  = 5;

  // counts/20 as ((counts >> 2) * 52429) >> 18, exact for counts up to 2^16
  localparam int WIN_RECIP = 52429;
  localparam int WIN_SHIFT = 18;

  // x/23040 as (((x >> 9) * 5965233) >> 28), exact for x below 2^31
  localparam int SET_SHIFT       = 9;
  localparam int SET_HI_W        = 22;
  localparam int SET_RECIP       = 5965233;
  localparam int SET_RECIP_SHIFT = 28;

  localparam int NUM_W = 32;           // divider dividend width
  localparam int DEN_W = 17;           // divider divisor width

  localparam logic [1:0] CFG_COUNTS    = 2'd0;
  localparam logic [1:0] CFG_INDEX_ENA = 2'd1;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_SET  = 1'b1
  } qei_kind_t;

  typedef struct packed {
    qei_kind_t          kind;
    logic               a_level;
    logic               b_level;
    logic               index_level;
    logic signed [16:0] set_angle;
  } qei_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       index;
    logic [CFG_W-1:0] data;
  } qei_cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } qei_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } qei_div_rsp_t;

endpackage

// ----- hdl/qei_front.sv -----
// ----------------------------------------------------------------------------
// qei_front
// Accepts input requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module qei_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic                in_a,
  input  logic                in_b,
  input  logic                in_index,
  input  logic signed [16:0]  in_angle,
  output logic                q_valid,
  input  logic                q_ready,
  output qei_pkg::qei_cmd_t   q_cmd
);

  qei_pkg::qei_cmd_t slot [2];
  logic              rd_ptr;
  logic              wr_ptr;
  logic [1:0]        fill;
  logic              push;
  logic              pop;
  qei_pkg::qei_cmd_t cmd_in;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot[rd_ptr];

  always_comb begin
    cmd_in.kind        = in_func ? qei_pkg::KIND_SET : qei_pkg::KIND_TICK;
    cmd_in.a_level     = in_a;
    cmd_in.b_level     = in_b;
    cmd_in.index_level = in_index;
    cmd_in.set_angle   = in_angle;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/qei_div.sv -----
// ----------------------------------------------------------------------------
// qei_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qei_div (
  input  logic                  clk,
  input  logic                  rst,
  input  qei_pkg::qei_div_req_t req,
  output qei_pkg::qei_div_rsp_t rsp
);

  localparam int NW = qei_pkg::NUM_W;
  localparam int DW = qei_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] step;
  logic [NW-1:0] numr;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          fits;
  logic          done;

  assign shifted  = {rem, numr[NW-1]};
  assign diff     = shifted - {1'b0, den};
  assign fits     = (shifted >= {1'b0, den});
  assign rsp.quot = numr;
  assign rsp.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (step == CW'(NW - 1));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        numr <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        rem  <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        numr <= {numr[NW-2:0], fits};
        step <= step + 1'b1;
        if (step == CW'(NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/qei_back.sv -----
// ----------------------------------------------------------------------------
// qei_back
// Filters, quadrature decode, index handling, set-angle and angle conversion.
// ----------------------------------------------------------------------------
module qei_back #(
  parameter int FILTER_LEN  = qei_pkg::FILTER_LEN_DEF,
  parameter int COUNT_WIDTH = qei_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qei_pkg::qei_cfg_t             cfg,
  output logic                          cfg_ready,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  qei_pkg::qei_cmd_t             q_cmd,
  output qei_pkg::qei_div_req_t         div_req,
  input  qei_pkg::qei_div_rsp_t         div_rsp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COUNT_WIDTH-1:0]        out_position,
  output logic [qei_pkg::ANGLE_W-1:0]   out_angle,
  output logic                          out_found,
  output logic [2:0]                    out_bad,
  output logic [15:0]                   out_total,
  output logic [COUNT_WIDTH-1:0]        out_capture
);

  localparam int PW = COUNT_WIDTH;
  localparam int KW = COUNT_WIDTH + 1;
  localparam int NW = qei_pkg::NUM_W;
  localparam int DW = qei_pkg::DEN_W;
  localparam int HW = qei_pkg::SET_HI_W;
  localparam logic [KW-1:0] COUNTS_MAX = KW'(1) << PW;
  localparam logic [2:0]    RUN_LAST   = 3'(FILTER_LEN - 1);
  localparam logic [17:0]   TURN18     = 18'(qei_pkg::ANGLE_TURN);
  localparam logic [17:0]   ANGLE_BIAS = 18'(3 * qei_pkg::ANGLE_TURN);
  localparam logic [KW-1:0] LIM_RST    = KW'(((qei_pkg::COUNTS_RST >> 2) * qei_pkg::WIN_RECIP)
                                             >> qei_pkg::WIN_SHIFT);

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_SETQ, S_ANGMUL, S_ANGDIV, S_OUT
  } state_t;

  state_t          state;
  logic [KW-1:0]   counts;
  logic            index_ena;
  logic [KW-1:0]   lim;
  logic            fa, fb;
  logic [2:0]      run_a, run_b;
  logic [PW-1:0]   position;
  logic            synced;
  logic [2:0]      miss_count;
  logic [15:0]     pulse_total;
  logic [PW-1:0]   capture;
  logic            last_index;
  logic [17:0]     red;
  logic [NW-1:0]   set_prod;
  logic [qei_pkg::ANGLE_W-1:0] angle_r;

  // tick datapath
  logic            fa_next, fb_next;
  logic [2:0]      run_a_next, run_b_next;
  logic [1:0]      ph_old, ph_new, dphase;
  logic [PW-1:0]   pos_step;
  logic            idx_edge, near_zero;
  logic [KW-1:0]   pos_ext;
  logic [KW-1:0]   cfg_counts;
  logic [NW-1:0]   lim_prod;
  logic [17:0]     angle_ext;

  // set-angle count by reciprocal multiplication
  logic [HW-1:0]   set_hi;
  logic [44:0]     set_mul;
  logic [NW-1:0]   set_cnt;

  function automatic logic [1:0] phase_of(input logic a, input logic b);
    phase_of = a ? (b ? 2'd2 : 2'd1) : (b ? 2'd3 : 2'd0);
  endfunction

  always_comb begin
    fa_next    = fa;
    run_a_next = 3'd0;
    if (q_cmd.a_level != fa) begin
      if (run_a >= RUN_LAST) fa_next = q_cmd.a_level;
      else run_a_next = run_a + 3'd1;
    end
    fb_next    = fb;
    run_b_next = 3'd0;
    if (q_cmd.b_level != fb) begin
      if (run_b >= RUN_LAST) fb_next = q_cmd.b_level;
      else run_b_next = run_b + 3'd1;
    end
    ph_old   = phase_of(fa, fb);
    ph_new   = phase_of(fa_next, fb_next);
    dphase   = ph_new - ph_old;
    pos_step = position;
    if (dphase == 2'd1) begin
      pos_step = ({1'b0, position} + KW'(1) >= counts) ? '0 : position + 1'b1;
    end else if (dphase == 2'd3) begin
      pos_step = (position == '0) ? PW'(counts - KW'(1)) : position - 1'b1;
    end
    pos_ext   = {1'b0, pos_step};
    idx_edge  = index_ena && q_cmd.index_level && !last_index;
    near_zero = !synced || (pos_ext > counts - lim) || (pos_ext < lim);
  end

  always_comb begin
    cfg_counts = cfg.data[KW-1:0];
    if (cfg.data < qei_pkg::CFG_W'(qei_pkg::COUNTS_MIN)) begin
      cfg_counts = KW'(qei_pkg::COUNTS_MIN);
    end else if (cfg.data > qei_pkg::CFG_W'(COUNTS_MAX)) begin
      cfg_counts = COUNTS_MAX;
    end
  end

  assign lim_prod  = NW'(cfg_counts >> 2) * NW'(qei_pkg::WIN_RECIP);
  assign angle_ext = {q_cmd.set_angle[16], q_cmd.set_angle};
  assign q_ready   = (state == S_IDLE);
  // registers change only with nothing queued, in work or waiting at the output
  assign cfg_ready = (state == S_IDLE) && !q_valid && !out_valid;

  assign set_hi  = set_prod[qei_pkg::SET_SHIFT +: HW];
  assign set_mul = 45'(set_hi) * 45'(qei_pkg::SET_RECIP);
  assign set_cnt = NW'(set_mul >> qei_pkg::SET_RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      counts      <= KW'(qei_pkg::COUNTS_RST);
      lim         <= LIM_RST;
      index_ena   <= 1'b0;
      fa          <= 1'b0;
      fb          <= 1'b0;
      run_a       <= '0;
      run_b       <= '0;
      position    <= '0;
      synced      <= 1'b0;
      miss_count  <= '0;
      pulse_total <= '0;
      capture     <= '0;
      last_index  <= 1'b0;
      out_valid   <= 1'b0;
      div_req     <= '0;
    end else begin
      div_req.start <= (state == S_ANGMUL);
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;

      if (cfg.valid && cfg_ready) begin
        unique case (cfg.index)
          qei_pkg::CFG_COUNTS: begin
            counts <= cfg_counts;
            lim    <= KW'(lim_prod >> qei_pkg::WIN_SHIFT);
            if ({1'b0, position} >= cfg_counts) position <= '0;
          end
          qei_pkg::CFG_INDEX_ENA: index_ena <= cfg.data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.kind == qei_pkg::KIND_SET) begin
              red   <= angle_ext + ANGLE_BIAS;
              state <= S_REDUCE;
            end else begin
              fa         <= fa_next;
              fb         <= fb_next;
              run_a      <= run_a_next;
              run_b      <= run_b_next;
              last_index <= q_cmd.index_level;
              position   <= (idx_edge && near_zero) ? '0 : pos_step;
              if (idx_edge) begin
                capture     <= pos_step;
                pulse_total <= pulse_total + 16'd1;
                if (near_zero) begin
                  synced     <= 1'b1;
                  miss_count <= '0;
                end else begin
                  if (miss_count != 3'd7) miss_count <= miss_count + 3'd1;
                  if (miss_count >= 3'(qei_pkg::BAD_LIMIT)) synced <= 1'b0;
                end
              end
              state <= S_ANGMUL;
            end
          end
        end
        S_REDUCE: begin
          if (red >= TURN18) begin
            red <= red - TURN18;
          end else begin
            set_prod <= NW'(red) * NW'(counts);
            state    <= S_SETQ;
          end
        end
        S_SETQ: begin
          position <= (set_cnt >= NW'(counts)) ? '0 : set_cnt[PW-1:0];
          synced   <= 1'b1;
          state    <= S_ANGMUL;
        end
        S_ANGMUL: begin
          div_req.num <= NW'(position) * NW'(qei_pkg::ANGLE_TURN);
          div_req.den <= DW'(counts);
          state       <= S_ANGDIV;
        end
        S_ANGDIV: begin
          if (div_rsp.done) begin
            angle_r <= div_rsp.quot[qei_pkg::ANGLE_W-1:0];
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_position <= position;
            out_angle    <= angle_r;
            out_found    <= synced;
            out_bad      <= miss_count;
            out_total    <= pulse_total;
            out_capture  <= capture;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // position always stays inside one turn
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, position} < counts)
    else $error("position outside counts per turn");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_angle < qei_pkg::ANGLE_W'(qei_pkg::ANGLE_TURN))
    else $error("angle beyond one turn");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_a <= RUN_LAST && run_b <= RUN_LAST)
    else $error("filter run count overran");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> state == S_OUT)
    else $error("result dropped while output stalled");

endmodule

// ----- hdl/quadrature_encoder_with_index.sv -----
// ----------------------------------------------------------------------------
// quadrature_encoder_with_index
// x4 quadrature decoder with glitch filters, index handling and angle output.
// ----------------------------------------------------------------------------
// Each request is either a line sample tick or a set-angle command, and each
// gives one result with count and angle. The shared 32-step bit-serial
// divider runs once for the angle of every request, and a set-angle command
// first wraps the angle with up to five compare-subtract steps and turns it
// into a count with a reciprocal multiplication. A two-entry request queue
// and the output register let either side stall on its own. Configuration
// writes are accepted only while the block is idle, with nothing queued or
// waiting at the output.
module quadrature_encoder_with_index #(
  parameter int FILTER_LEN  = qei_pkg::FILTER_LEN_DEF,
  parameter int COUNT_WIDTH = qei_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // a_level, b_level, index_level, set_angle[16:0]
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // position_count[15:0], angle[14:0], found_flag, bad_pulse_count[2:0],
  // index_pulse_total[15:0], count_at_last_index[15:0]
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  qei_pkg::qei_cmd_t     q_cmd;
  logic                  q_valid;
  logic                  q_ready;
  qei_pkg::qei_cfg_t     cfg;
  qei_pkg::qei_div_req_t div_req;
  qei_pkg::qei_div_rsp_t div_rsp;
  logic [COUNT_WIDTH-1:0]      o_pos;
  logic [qei_pkg::ANGLE_W-1:0] o_angle;
  logic                        o_found;
  logic [2:0]                  o_bad;
  logic [15:0]                 o_total;
  logic [COUNT_WIDTH-1:0]      o_cap;

  always_comb begin
    cfg.valid = cfg_valid;
    cfg.index = cfg_index;
    cfg.data  = cfg_data;
  end

  qei_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_func  (s_axis_tuser),
    .in_a     (s_axis_tdata[0]),
    .in_b     (s_axis_tdata[1]),
    .in_index (s_axis_tdata[2]),
    .in_angle (s_axis_tdata[19:3]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  qei_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  qei_back #(
    .FILTER_LEN  (FILTER_LEN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cfg_ready    (cfg_ready),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_cmd        (q_cmd),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_position (o_pos),
    .out_angle    (o_angle),
    .out_found    (o_found),
    .out_bad      (o_bad),
    .out_total    (o_total),
    .out_capture  (o_cap)
  );

  assign m_axis_tdata = {5'd0, 16'(o_cap), o_total, o_bad, o_found, o_angle, 16'(o_pos)};

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for quadrature_encoder_with_index: drives encoder
// line samples and set-angle requests through several register settings,
// predicts every result in-line and checks it field by field.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3000000;

  class result_scoreboard;
    logic [71:0] expected_q[$];
    int          mismatches;

    function void note(logic [71:0] r);
      expected_q.push_back(r);
    endfunction

    function void check(logic [71:0] act);
      int          lo[6];
      int          wd[6];
      string       nm[6];
      logic [71:0] e;
      logic [71:0] m;
      lo = '{0, 16, 31, 32, 35, 51};
      wd = '{16, 15, 1, 3, 16, 16};
      nm = '{"position_count", "angle", "found_flag", "bad_pulse_count",
             "index_pulse_total", "count_at_last_index"};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", act);
        return;
      end
      e = expected_q.pop_front();
      for (int f = 0; f < 6; f++) begin
        m = ((72'd1 << wd[f]) - 72'd1) << lo[f];
        if ((e & m) != (act & m)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%s mismatch: expected %0d got %0d", nm[f],
                     (e & m) >> lo[f], (act & m) >> lo[f]);
        end
      end
      if (act[71:67] != 5'd0) begin
        mismatches++;
        if (mismatches <= 10) $display("padding bits set: %h", act);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // a_level, b_level, index_level, set_angle[16:0]
  logic        s_axis_tuser;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // position_count, angle, found_flag, bad_pulse_count, index_pulse_total,
  // count_at_last_index
  logic [71:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  quadrature_encoder_with_index dut (.*);

  result_scoreboard sb = new();

  // predictor state
  int unsigned counts_cfg, index_ena;
  bit          filt_a, filt_b, prev_index;
  int unsigned run_a, run_b, pos, bad_cnt, pulse_cnt, idx_capture;
  bit          in_sync;

  bit idle_en;
  bit rx_hold_req;
  int phase_pos;   // encoder phase of the generated motion
  int cycles;

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);

  function automatic int unsigned quad_phase(bit a, bit b);
    return a ? (b ? 2 : 1) : (b ? 3 : 0);
  endfunction

  function automatic void filter_step(bit raw, ref bit lvl, ref int unsigned run);
    if (raw == lvl) run = 0;
    else if (run + 1 >= qei_pkg::FILTER_LEN_DEF) begin
      lvl = raw;
      run = 0;
    end else run = (run + 1) & 7;
  endfunction

  function automatic logic [71:0] advance_encoder(qei_pkg::qei_kind_t kind, bit a, bit b,
                                                   bit i, logic signed [16:0] ang);
    int unsigned old_ph, d, lim;
    int          deg;
    longint      cnt;
    logic [71:0] r;
    if (kind == qei_pkg::KIND_TICK) begin
      old_ph = quad_phase(filt_a, filt_b);
      filter_step(a, filt_a, run_a);
      filter_step(b, filt_b, run_b);
      d = (quad_phase(filt_a, filt_b) - old_ph) & 3;
      if (d == 1) pos = (pos + 1 >= counts_cfg) ? 0 : ((pos + 1) & 32'hFFFF);
      else if (d == 3) pos = (pos == 0) ? ((counts_cfg - 1) & 32'hFFFF) : pos - 1;
      if (index_ena != 0 && i && !prev_index) begin
        lim = counts_cfg / 20;
        idx_capture = pos & 32'hFFFF;
        pulse_cnt = (pulse_cnt + 1) & 32'hFFFF;
        if (!in_sync || pos > counts_cfg - lim || pos < lim) begin
          pos = 0;
          in_sync = 1;
          bad_cnt = 0;
        end else begin
          if (bad_cnt < 7) bad_cnt++;
          if (bad_cnt > qei_pkg::BAD_LIMIT) in_sync = 0;
        end
      end
      prev_index = i;
    end else begin
      deg = int'(ang) % qei_pkg::ANGLE_TURN;
      if (deg < 0) deg += qei_pkg::ANGLE_TURN;
      cnt = (longint'(deg) * counts_cfg) / qei_pkg::ANGLE_TURN;
      if (cnt >= counts_cfg) cnt = 0;
      pos = 32'(cnt) & 32'hFFFF;
      in_sync = 1;
    end
    r = '0;
    r[15:0]  = 16'(pos);
    r[30:16] = 15'((longint'(pos) * qei_pkg::ANGLE_TURN) / counts_cfg);
    r[31]    = in_sync;
    r[34:32] = 3'(bad_cnt);
    r[50:35] = 16'(pulse_cnt);
    r[66:51] = 16'(idx_capture);
    return r;
  endfunction

  task automatic send(qei_pkg::qei_kind_t kind, bit a, bit b, bit i,
                      logic signed [16:0] ang);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, ang, i, b, a};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note(advance_encoder(kind, a, b, i, ang));
  endtask

  task automatic tick(bit a, bit b, bit i);
    send(qei_pkg::KIND_TICK, a, b, i, 17'($urandom));
  endtask

  task automatic set_angle(int ang);
    send(qei_pkg::KIND_SET, 1'($urandom), 1'($urandom), 1'($urandom), 17'(ang));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    int unsigned v;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == qei_pkg::CFG_COUNTS) begin
      v = 32'(val);
      if (v < qei_pkg::COUNTS_MIN) v = qei_pkg::COUNTS_MIN;
      if (v > 65536) v = 65536;
      counts_cfg = v;
      if (pos >= counts_cfg) pos = 0;
    end else index_ena = 32'(val[0]);
    @(posedge clk);
  endtask

  // one quadrature step in direction dir, held long enough to pass the filter,
  // sometimes with a short glitch on one line first
  task automatic step_motion(int dir, bit idx);
    bit la, lb;
    int n;
    phase_pos = (phase_pos + dir) & 3;
    la = (phase_pos == 1 || phase_pos == 2);
    lb = (phase_pos == 2 || phase_pos == 3);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) tick(!la, lb, idx);
    n = $urandom_range(qei_pkg::FILTER_LEN_DEF, qei_pkg::FILTER_LEN_DEF + 3);
    for (int k = 0; k < n; k++) tick(la, lb, idx && k < 2);
  endtask

  task automatic run_phase(int items);
    int sel;
    int dir;
    for (int done_items = 0; done_items < items; ) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        dir = $urandom_range(0, 1) ? 1 : -1;
        repeat ($urandom_range(1, 8)) begin
          step_motion(dir, 1'b0);
          done_items += 7;
        end
      end else if (sel < 75) begin
        step_motion($urandom_range(0, 1) ? 1 : -1, 1'b1);
        done_items += 7;
      end else if (sel < 85) begin
        case ($urandom_range(0, 3))
          0: set_angle($urandom_range(0, 69119) - 23040);
          1: set_angle($urandom_range(0, 200));
          2: set_angle(23040 - $urandom_range(1, 200));
          default: set_angle($urandom_range(0, 1) ? -23040 : 46079);
        endcase
        done_items++;
      end else begin
        // noise, including both lines flipping together
        repeat ($urandom_range(1, 8)) begin
          tick(1'($urandom), 1'($urandom), 1'($urandom));
          done_items++;
        end
      end
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        for (int c = 0; c < 400; c++) @(posedge clk);
        rx_hold_req = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = qei_pkg::KIND_TICK;
    cfg_valid = 1'b0;
    cfg_index = qei_pkg::CFG_COUNTS;
    cfg_data = '0;
    idle_en = 1;
    counts_cfg = qei_pkg::COUNTS_RST;
    index_ena = 0;
    phase_pos = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: angle extremes, wrap and truncation
    set_angle(-23040);
    set_angle(46079);
    set_angle(0);
    set_angle(23039);
    set_angle(-1);
    set_angle(11520);
    // both lines change at once: ignored
    repeat (6) tick(1, 1, 0);
    // index edges while disabled
    tick(1, 1, 1);
    tick(1, 1, 0);
    tick(1, 1, 1);
    tick(0, 0, 0);
    set_angle(23039);
    drain();
    // shrinking counts below position clears it
    write_reg(qei_pkg::CFG_COUNTS, 17'd100);
    write_reg(qei_pkg::CFG_INDEX_ENA, 17'd1);
    repeat (3) step_motion(1, 1'b0);
    step_motion(1, 1'b1);
    run_phase(300);
    drain();

    write_reg(qei_pkg::CFG_COUNTS, 17'd1);
    run_phase(200);
    drain();

    write_reg(qei_pkg::CFG_COUNTS, 17'h10000);
    rx_hold_req = 1;
    run_phase(300);
    drain();

    write_reg(qei_pkg::CFG_COUNTS, 17'h1FFFF);
    write_reg(qei_pkg::CFG_INDEX_ENA, 17'd0);
    run_phase(150);
    drain();

    write_reg(qei_pkg::CFG_COUNTS, 17'd0);
    write_reg(qei_pkg::CFG_INDEX_ENA, 17'd1);
    run_phase(150);
    drain();

    write_reg(qei_pkg::CFG_COUNTS, 17'd360);
    run_phase(300);
    drain();

    write_reg(qei_pkg::CFG_COUNTS, 17'd1000);
    idle_en = 0;
    run_phase(300);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/qei_pkg.sv
hdl/qei_front.sv
hdl/qei_div.sv
hdl/qei_back.sv
hdl/quadrature_encoder_with_index.sv
tb/tb.sv
